// ===== hdl/bgcnco_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcnco_pkg
// Shared types, register codes, default sizes and the sine table generator
// for the burst gated complex NCO.
// ----------------------------------------------------------------------------
package bgcnco_pkg;

  // default sizes (top level parameters take these)
  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int COUNT_BITS_DEF      = 24;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_WIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_PER  = 3'd7;

  // burst modes
  localparam logic [1:0] MODE_CONT   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_REPEAT = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // what a sample carries
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_OFFSET,
    KIND_TONE
  } kind_e;

  localparam int KIND_W = $bits(kind_e);

  // configuration register file
  typedef struct packed {
    logic signed [31:0] phase_increment;
    logic [15:0]        phase_offset;
    logic [14:0]        amplitude;
    logic [31:0]        dc_offset;
    logic [1:0]         burst_mode;
    logic [23:0]        initial_delay;
    logic [47:0]        burst_window;
    logic [23:0]        burst_period;
  } cfg_t;

  // Quarter-wave sine entry k, Q30 Taylor/Horner evaluation, scaled to
  // full scale of sb-bit samples. Elaboration time only.
  function automatic longint unsigned sine_value(input int k, input int ta, input int sb);
    longint unsigned one_q30;
    longint unsigned y;
    longint unsigned y2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    longint unsigned full;
    one_q30 = 64'd1 << 30;
    full    = (64'd1 << (sb - 1)) - 64'd1;
    y  = (64'd1686629713 * (2 * longint'(k) + 1)) >> (ta + 1);
    y2 = (y * y) >> 30;
    t  = one_q30;
    t  = one_q30 - ((y2 * t) >> 30) / 156;
    t  = one_q30 - ((y2 * t) >> 30) / 110;
    t  = one_q30 - ((y2 * t) >> 30) / 72;
    t  = one_q30 - ((y2 * t) >> 30) / 42;
    t  = one_q30 - ((y2 * t) >> 30) / 20;
    t  = one_q30 - ((y2 * t) >> 30) / 6;
    s  = (y * t) >> 30;
    v  = (s * full + (one_q30 >> 1)) >> 30;
    if (v > full) begin
      v = full;
    end
    return v;
  endfunction

endpackage

// ===== hdl/bgcnco_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcnco_front
// Timing front end: keeps the elapsed count, the burst window position and
// the phase accumulator, classifies each item as zero, offset or tone and
// hands the kind and the table phase of each item to the queue.
// ----------------------------------------------------------------------------
module bgcnco_front #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int COUNT_BITS      = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bgcnco_pkg::cfg_t              cfg_i,
  input  logic                          accept_i,
  input  logic                          restart_i,
  output bgcnco_pkg::kind_e             kind_o,
  output logic [TABLE_ADDR_BITS+1:0]    phase_o
);
  import bgcnco_pkg::*;

  localparam int CW = COUNT_BITS;
  localparam int EW = COUNT_BITS + 1;
  localparam int PW = PHASE_BITS;
  localparam int QW = TABLE_ADDR_BITS + 2;

  logic [EW-1:0] elapsed_q, elapsed_d;
  logic [CW-1:0] wpos_q, wpos_d;
  logic [PW-1:0] acc_q, acc_d;

  logic [EW-1:0] ec;
  logic [CW-1:0] wp0, wp, idly, bd, bl, per_raw, per;
  logic [CW:0]   wp_inc;
  logic [PW-1:0] acc, ph, inc, ofs, phase_sum;
  logic          start;
  kind_e         kind;

  // time registers at count width
  assign idly    = CW'(cfg_i.initial_delay);
  assign bd      = CW'(cfg_i.burst_window[23:0]);
  assign bl      = CW'(cfg_i.burst_window[47:24]);
  assign per_raw = CW'(cfg_i.burst_period);
  assign per     = (per_raw == '0) ? CW'(1) : per_raw;

  assign inc = PW'(cfg_i.phase_increment);
  assign ofs = PW'(cfg_i.phase_offset) << (PW - 16);

  // classification and next state
  always_comb begin
    ec        = restart_i ? '0 : elapsed_q;
    wp0       = restart_i ? '0 : wpos_q;
    acc       = restart_i ? '0 : acc_q;
    kind      = KIND_ZERO;
    start     = 1'b0;
    wp        = wp0;
    wp_inc    = '0;
    elapsed_d = ec;
    wpos_d    = wp0;
    if (ec < {1'b0, idly}) begin
      // still in the initial delay
      elapsed_d = ec + EW'(1);
    end else begin
      elapsed_d = (ec != '1) ? ec + EW'(1) : ec;
      if (cfg_i.burst_mode == MODE_REPEAT) begin
        wp = (wp0 >= per) ? '0 : wp0;
        if (wp >= bd && (wp - bd) < bl) begin
          kind  = KIND_TONE;
          start = (wp == bd);
        end else begin
          kind = KIND_OFFSET;
        end
        wp_inc = {1'b0, wp} + (CW+1)'(1);
        wpos_d = (wp_inc >= {1'b0, per}) ? '0 : wp_inc[CW-1:0];
      end else begin
        priority if (cfg_i.burst_mode == MODE_CONT) begin
          kind  = KIND_TONE;
          start = (wp0 == '0);
        end else if (cfg_i.burst_mode == MODE_SINGLE && wp0 != '1) begin
          if (wp0 < bd) begin
            kind = KIND_OFFSET;
          end else if ((wp0 - bd) < bl) begin
            kind  = KIND_TONE;
            start = (wp0 == bd);
          end
        end else begin
          kind = KIND_ZERO;
        end
        wpos_d = (wp0 != '1) ? wp0 + CW'(1) : wp0;
      end
    end
    // phase restarts at each burst start
    ph        = start ? '0 : acc;
    phase_sum = ph + ofs;
    acc_d     = (kind == KIND_TONE) ? ph + inc : acc;
  end

  // state update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      wpos_q    <= '0;
      acc_q     <= '0;
    end else if (accept_i) begin
      elapsed_q <= elapsed_d;
      wpos_q    <= wpos_d;
      acc_q     <= acc_d;
    end
  end

  assign kind_o  = kind;
  assign phase_o = phase_sum[PW-1 -: QW];

endmodule

// ===== hdl/bgcnco_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcnco_fifo
// Short first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
module bgcnco_fifo #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);

endmodule

// ===== hdl/bgcnco_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcnco_back
// Sample back end: quarter-wave table lookup for cos and sin, amplitude
// multiply, dc offset add and saturation, three register stages that all
// hold while the output is stalled.
// ----------------------------------------------------------------------------
module bgcnco_back #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bgcnco_pkg::cfg_t               cfg_i,
  input  logic                           empty_i,
  input  bgcnco_pkg::kind_e              kind_i,
  input  logic [TABLE_ADDR_BITS+1:0]     phase_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]  i_sample_o,
  output logic signed [SAMPLE_BITS-1:0]  q_sample_o,
  output logic                           tone_active_o
);
  import bgcnco_pkg::*;

  localparam int TA    = TABLE_ADDR_BITS;
  localparam int SB    = SAMPLE_BITS;
  localparam int TSIZE = 1 << TA;
  localparam int PRW   = SB + 16;
  localparam int SUMW  = SB + 2;
  localparam int EXW   = SB + 16;
  localparam int UP    = (SB >= 16) ? SB - 16 : 0;
  localparam int DN    = (SB < 16) ? 16 - SB : 0;

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((1 << (SB - 1)) - 1);
  localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(-(1 << (SB - 1)));

  typedef logic [SB-2:0] rom_t [TSIZE];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < TSIZE; k++) begin
      r[k] = (SB-1)'(sine_value(k, TA, SB));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Q1.15 offset brought to the sample width, floor when narrowing
  function automatic logic signed [SB-1:0] align15(input logic [15:0] raw);
    logic signed [EXW-1:0] ext;
    ext = EXW'($signed(raw));
    return SB'((ext <<< UP) >>> DN);
  endfunction

  function automatic logic signed [SB-1:0] sat(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return SB'(c);
  endfunction

  logic en;

  // stage 1: table read
  logic            v1_q;
  kind_e           kind1_q;
  logic [SB-2:0]   sin_mag_q, cos_mag_q;
  logic            sin_neg_q, cos_neg_q;
  logic [TA-1:0]   idx, addr_s, addr_c;
  logic [1:0]      quad_s, quad_c;

  // stage 2: amplitude product
  logic                   v2_q;
  kind_e                  kind2_q;
  logic signed [PRW-1:0]  prod_i_q, prod_q_q;
  logic signed [SB-1:0]   sin_trig, cos_trig;
  logic signed [PRW-1:0]  amp_s;

  // stage 3: output register
  logic                   out_valid_q;
  logic signed [SB-1:0]   i_q, q_q;
  logic                   tone_q;
  logic signed [SB-1:0]   ioff, qoff;
  logic signed [SUMW-1:0] i_tone, q_tone;

  // whole back end moves unless the output holds a stalled item
  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && !empty_i;

  // cos is the sine one quadrant ahead
  assign idx    = phase_i[TA-1:0];
  assign quad_s = phase_i[TA+1:TA];
  assign quad_c = quad_s + 2'd1;
  assign addr_s = quad_s[0] ? ~idx : idx;
  assign addr_c = quad_c[0] ? ~idx : idx;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sin_mag_q <= SINE_ROM[addr_s];
      cos_mag_q <= SINE_ROM[addr_c];
      sin_neg_q <= quad_s[1];
      cos_neg_q <= quad_c[1];
      kind1_q   <= kind_i;
    end
  end

  // signed trig values and products
  assign sin_trig = sin_neg_q ? -SB'({1'b0, sin_mag_q}) : SB'({1'b0, sin_mag_q});
  assign cos_trig = cos_neg_q ? -SB'({1'b0, cos_mag_q}) : SB'({1'b0, cos_mag_q});
  assign amp_s    = PRW'($signed({1'b0, cfg_i.amplitude}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_i_q <= amp_s * PRW'(cos_trig);
      prod_q_q <= amp_s * PRW'(sin_trig);
      kind2_q  <= kind1_q;
    end
  end

  // rounding, offset add, saturation
  assign ioff   = align15(cfg_i.dc_offset[15:0]);
  assign qoff   = align15(cfg_i.dc_offset[31:16]);
  assign i_tone = SUMW'((prod_i_q + PRW'(16384)) >>> 15) + SUMW'(ioff);
  assign q_tone = SUMW'((prod_q_q + PRW'(16384)) >>> 15) + SUMW'(qoff);

  always_ff @(posedge clk_i) begin
    if (en) begin
      unique case (kind2_q)
        KIND_TONE: begin
          i_q <= sat(i_tone);
          q_q <= sat(q_tone);
        end
        KIND_OFFSET: begin
          i_q <= ioff;
          q_q <= qoff;
        end
        default: begin
          i_q <= '0;
          q_q <= '0;
        end
      endcase
      tone_q <= (kind2_q == KIND_TONE);
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop_o;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign i_sample_o    = i_q;
  assign q_sample_o    = q_q;
  assign tone_active_o = tone_q;

endmodule

// ===== hdl/burst_gated_complex_nco_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_gated_complex_nco_unit
// Complex NCO with initial delay and single or repeated burst gating.
// One restart item in gives one I/Q sample item out.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+---------------------------
//   input    | in        | in_valid_i / in_stall_o   | restart_i
//   output   | out       | out_valid_o / out_stall_i | i_sample_o, q_sample_o,
//            |           |                           | tone_active_o
//   config   | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item per clock sustained while the output is not stalled. An accepted
// item passes the queue, sine table read, multiply, round and saturate.
// The front end updates the timing state and the phase accumulator in the
// cycle an item is accepted; the 4-entry queue lets it keep going while the
// output is stalled, and in_stall_o rises only when that queue is full.
// Reset clears all timing state and loads the register defaults at once.
// ----------------------------------------------------------------------------
module burst_gated_complex_nco_unit #(
  parameter int PHASE_BITS      = bgcnco_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = bgcnco_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = bgcnco_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS      = bgcnco_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bgcnco_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bgcnco_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      i_sample_o,
  output logic signed [SAMPLE_BITS-1:0]      q_sample_o,
  output logic                               tone_active_o
);
  import bgcnco_pkg::*;

  localparam int QW = TABLE_ADDR_BITS + 2;
  localparam int IW = KIND_W + QW;

  cfg_t           cfg_q;
  logic           accept;
  kind_e          f_kind;
  logic [QW-1:0]  f_phase;
  logic [IW-1:0]  q_wdata, q_rdata;
  logic           q_full, q_empty, b_pop;
  kind_e          b_kind;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_increment <= '0;
      cfg_q.phase_offset    <= '0;
      cfg_q.amplitude       <= 15'd32767;
      cfg_q.dc_offset       <= '0;
      cfg_q.burst_mode      <= MODE_CONT;
      cfg_q.initial_delay   <= '0;
      cfg_q.burst_window    <= '0;
      cfg_q.burst_period    <= 24'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PHASE_INC:  cfg_q.phase_increment <= $signed(cfg_wdata_i[31:0]);
        REG_PHASE_OFS:  cfg_q.phase_offset    <= cfg_wdata_i[15:0];
        REG_AMPLITUDE:  cfg_q.amplitude       <= cfg_wdata_i[14:0];
        REG_DC_OFFSET:  cfg_q.dc_offset       <= cfg_wdata_i[31:0];
        REG_BURST_MODE: cfg_q.burst_mode      <= cfg_wdata_i[1:0];
        REG_INIT_DELAY: cfg_q.initial_delay   <= cfg_wdata_i[23:0];
        REG_BURST_WIN:  cfg_q.burst_window    <= cfg_wdata_i[47:0];
        REG_BURST_PER:  cfg_q.burst_period    <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  bgcnco_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .restart_i (restart_i),
    .kind_o    (f_kind),
    .phase_o   (f_phase)
  );

  assign q_wdata = {f_kind, f_phase};

  bgcnco_fifo #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (q_wdata),
    .pop_i   (b_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign b_kind = kind_e'(q_rdata[IW-1 -: KIND_W]);

  bgcnco_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (q_empty),
    .kind_i        (b_kind),
    .phase_i       (q_rdata[QW-1:0]),
    .pop_o         (b_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .i_sample_o    (i_sample_o),
    .q_sample_o    (q_sample_o),
    .tone_active_o (tone_active_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted item is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !q_empty)
    else $error("accepted item missing from queue");

  // the back end never reads an empty queue
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  // a full queue always means the output side is holding a stalled sample
  a_full_only_when_out_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !$past(q_full)) |-> $past(out_valid_o && out_stall_i))
    else $error("queue filled while the back end was free");
`endif

endmodule
